// ===== hw/rtl/fgg_pkg.sv =====
// Shared types, constants and the arctangent table for the formation goal step.
// No dependencies; fgg_cordic, fgg_ctrl, fgg_dp and the top level refer to this package by scope.
`default_nettype none
package fgg_pkg;

    localparam int TAB_LEN      = 24;
    localparam int XW           = 40;  // CORDIC x/y datapath width
    localparam int ZW           = 34;  // CORDIC angle width, 2^-32 turn units
    localparam int INV_GAIN_Q30 = 652032874;
    localparam int INV_GAIN_Q16 = 39797;
    localparam int ONE_Q16      = 65536;
    localparam int QUARTER_BRAD = 16384;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_ENV_W     = 2'd1,
        CFG_HEAD_S    = 2'd2,
        CFG_HEAD_OFF  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CM_VEC = 1'b0,
        CM_ROT = 1'b1
    } t_cmode;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_VEC_CAP, OP_SETUP, OP_MAG, OP_BL1, OP_BL2,
        OP_GE_GO, OP_GE_CAP, OP_GF_GO, OP_GF_CAP, OP_R_GO, OP_R_CAP,
        OP_F_GO, OP_F_CAP,
        OP_X1, OP_X2, OP_X3, OP_X4, OP_X5, OP_X6,
        OP_Y1, OP_Y2, OP_Y3, OP_Y4, OP_Y5, OP_Y6,
        OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_VEC_WAIT, ST_SETUP, ST_MAG, ST_BL1, ST_BL2,
        ST_GE_GO, ST_GE_WAIT, ST_GF_GO, ST_GF_WAIT, ST_R_GO, ST_R_WAIT,
        ST_F_GO, ST_F_WAIT,
        ST_X1, ST_X2, ST_X3, ST_X4, ST_X5, ST_X6,
        ST_Y1, ST_Y2, ST_Y3, ST_Y4, ST_Y5, ST_Y6,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cordic_done;
        logic is_update;
        logic out_free;
    } t_dp_status;

    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fgg_if.sv =====
// Valid/ready channel interfaces for the input word and the result word.
// Depends on nothing; used by the top level of the formation goal step.
`default_nettype none
interface fgg_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_yaw;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] gradient_heading;

    modport source (output valid, cmd, robot_x, robot_y, robot_yaw, target_x, target_y,
                    gradient_heading, input ready);
    modport sink (input valid, cmd, robot_x, robot_y, robot_yaw, target_x, target_y,
                  gradient_heading, output ready);
endinterface

interface fgg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;

    modport source (output valid, goal_x, goal_y, goal_heading, input ready);
    modport sink (input valid, goal_x, goal_y, goal_heading, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/formation_gradient_goal_step.sv =====
// Top level of the formation goal step: sequencer, datapath and the two channels.
// Depends on fgg_pkg, fgg_if, fgg_ctrl and fgg_dp (which holds fgg_cordic).
`default_nettype none
// One input word is taken at a time, and each gives exactly one result word. A set-up word
// (cmd 0) records the bearing to the formation target and returns the robot pose unchanged.
// An update word (cmd 1) runs the single shared CORDIC unit through one vectoring pass (bearing
// and range to the target) and four rotation passes (heading gate, bearing gate, heading
// cosine/sine and bearing cosine/sine) one after another, one micro-rotation per clock, and
// the shared multiplier through the blend and the weighted mix. The result sits in an output
// register, so a new word is accepted while the previous result still waits, and the block
// only stalls at the end of a word if that register has not been emptied. Configuration
// registers are written through a plain write port; the user must write them only while the
// block is idle, and the block itself does not enforce it.
module formation_gradient_goal_step #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    fgg_in_if.sink           i_in,
    fgg_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    fgg_pkg::t_ctrl_cmd  w_cmd;
    fgg_pkg::t_dp_status w_st;
    logic                w_in_ready;

    // The sequencer owns the input handshake; the datapath owns the result register.
    fgg_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .i_status(w_st),
        .o_cmd(w_cmd)
    );

    fgg_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd),
        .o_status(w_st),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd_bit(i_in.cmd),
        .i_robot_x(i_in.robot_x),
        .i_robot_y(i_in.robot_y),
        .i_robot_yaw(i_in.robot_yaw),
        .i_target_x(i_in.target_x),
        .i_target_y(i_in.target_y),
        .i_gradient_heading(i_in.gradient_heading),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_goal_x(o_out.goal_x),
        .o_goal_y(o_out.goal_y),
        .o_goal_heading(o_out.goal_heading)
    );

    assign i_in.ready = w_in_ready;

    // Once a word is taken, no second word is taken in the next cycle.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("second word accepted while busy");

    // The CORDIC only finishes while a word is in flight.
    a_cordic_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.cordic_done |-> !w_in_ready)
        else $error("CORDIC finished while idle");

    // A result is written only when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == fgg_pkg::OP_EMIT || w_cmd.op == fgg_pkg::OP_SETUP) |-> w_st.out_free)
        else $error("result written over a pending word");

    // A written result shows up as valid in the next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == fgg_pkg::OP_EMIT || w_cmd.op == fgg_pkg::OP_SETUP) |=> o_out.valid)
        else $error("result written but not presented");
endmodule
`default_nettype wire

// ===== hw/rtl/fgg_cordic.sv =====
// Shared iterative CORDIC: one micro-rotation per cycle, vectoring or rotation mode.
// Depends on fgg_pkg for widths, mode codes and the arctangent table.
`default_nettype none
module fgg_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire fgg_pkg::t_cmode               i_mode,
    input  wire logic signed [fgg_pkg::XW-1:0] i_x,
    input  wire logic signed [fgg_pkg::XW-1:0] i_y,
    input  wire logic signed [fgg_pkg::ZW-1:0] i_z,
    output logic                               o_done,
    output logic signed [fgg_pkg::XW-1:0]      o_x,
    output logic signed [fgg_pkg::XW-1:0]      o_y,
    output logic signed [fgg_pkg::ZW-1:0]      o_z
);
    localparam int NSTEP = (CORDIC_STEPS > fgg_pkg::TAB_LEN) ? fgg_pkg::TAB_LEN : CORDIC_STEPS;
    localparam int CW    = $clog2(NSTEP + 1);

    logic                          r_busy, r_done;
    logic [CW-1:0]                 r_cnt;
    fgg_pkg::t_cmode               r_mode;
    logic signed [fgg_pkg::XW-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [fgg_pkg::ZW-1:0] r_z, n_z, at;
    logic                          up;

    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        at = fgg_pkg::ZW'(fgg_pkg::atan_at(5'(r_cnt)));
        // In vectoring the sign of y steers, in rotation the sign of the residual angle.
        up = (r_mode == fgg_pkg::CM_VEC) ? ~r_y[fgg_pkg::XW-1] : ~r_z[fgg_pkg::ZW-1];
        if (r_mode == fgg_pkg::CM_VEC) begin
            n_x = up ? r_x + ys : r_x - ys;
            n_y = up ? r_y - xs : r_y + xs;
            n_z = up ? r_z + at : r_z - at;
        end else begin
            n_x = up ? r_x - ys : r_x + ys;
            n_y = up ? r_y + xs : r_y - xs;
            n_z = up ? r_z - at : r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NSTEP - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_mode;
            r_x    <= i_x;
            r_y    <= i_y;
            r_z    <= i_z;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule
`default_nettype wire

// ===== hw/rtl/fgg_ctrl.sv =====
// Sequencer that walks the datapath through one set-up or update word.
// Depends on fgg_pkg for the state, operation and status types.
`default_nettype none
module fgg_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fgg_pkg::t_dp_status i_status,
    output fgg_pkg::t_ctrl_cmd       o_cmd
);
    fgg_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = fgg_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            fgg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = fgg_pkg::OP_LOAD;
                    n_state  = fgg_pkg::ST_VEC_WAIT;
                end
            end
            fgg_pkg::ST_VEC_WAIT: begin
                if (i_status.cordic_done) begin
                    o_cmd.op = fgg_pkg::OP_VEC_CAP;
                    n_state  = i_status.is_update ? fgg_pkg::ST_MAG : fgg_pkg::ST_SETUP;
                end
            end
            fgg_pkg::ST_SETUP: begin
                if (i_status.out_free) begin
                    o_cmd.op = fgg_pkg::OP_SETUP;
                    n_state  = fgg_pkg::ST_IDLE;
                end
            end
            fgg_pkg::ST_MAG: begin o_cmd.op = fgg_pkg::OP_MAG; n_state = fgg_pkg::ST_BL1; end
            fgg_pkg::ST_BL1: begin o_cmd.op = fgg_pkg::OP_BL1; n_state = fgg_pkg::ST_BL2; end
            fgg_pkg::ST_BL2: begin o_cmd.op = fgg_pkg::OP_BL2; n_state = fgg_pkg::ST_GE_GO; end
            fgg_pkg::ST_GE_GO: begin
                o_cmd.op = fgg_pkg::OP_GE_GO;
                n_state  = fgg_pkg::ST_GE_WAIT;
            end
            fgg_pkg::ST_GE_WAIT: begin
                if (i_status.cordic_done) begin
                    o_cmd.op = fgg_pkg::OP_GE_CAP;
                    n_state  = fgg_pkg::ST_GF_GO;
                end
            end
            fgg_pkg::ST_GF_GO: begin
                o_cmd.op = fgg_pkg::OP_GF_GO;
                n_state  = fgg_pkg::ST_GF_WAIT;
            end
            fgg_pkg::ST_GF_WAIT: begin
                if (i_status.cordic_done) begin
                    o_cmd.op = fgg_pkg::OP_GF_CAP;
                    n_state  = fgg_pkg::ST_R_GO;
                end
            end
            fgg_pkg::ST_R_GO: begin
                o_cmd.op = fgg_pkg::OP_R_GO;
                n_state  = fgg_pkg::ST_R_WAIT;
            end
            fgg_pkg::ST_R_WAIT: begin
                if (i_status.cordic_done) begin
                    o_cmd.op = fgg_pkg::OP_R_CAP;
                    n_state  = fgg_pkg::ST_F_GO;
                end
            end
            fgg_pkg::ST_F_GO: begin
                o_cmd.op = fgg_pkg::OP_F_GO;
                n_state  = fgg_pkg::ST_F_WAIT;
            end
            fgg_pkg::ST_F_WAIT: begin
                if (i_status.cordic_done) begin
                    o_cmd.op = fgg_pkg::OP_F_CAP;
                    n_state  = fgg_pkg::ST_X1;
                end
            end
            fgg_pkg::ST_X1: begin o_cmd.op = fgg_pkg::OP_X1; n_state = fgg_pkg::ST_X2; end
            fgg_pkg::ST_X2: begin o_cmd.op = fgg_pkg::OP_X2; n_state = fgg_pkg::ST_X3; end
            fgg_pkg::ST_X3: begin o_cmd.op = fgg_pkg::OP_X3; n_state = fgg_pkg::ST_X4; end
            fgg_pkg::ST_X4: begin o_cmd.op = fgg_pkg::OP_X4; n_state = fgg_pkg::ST_X5; end
            fgg_pkg::ST_X5: begin o_cmd.op = fgg_pkg::OP_X5; n_state = fgg_pkg::ST_X6; end
            fgg_pkg::ST_X6: begin o_cmd.op = fgg_pkg::OP_X6; n_state = fgg_pkg::ST_Y1; end
            fgg_pkg::ST_Y1: begin o_cmd.op = fgg_pkg::OP_Y1; n_state = fgg_pkg::ST_Y2; end
            fgg_pkg::ST_Y2: begin o_cmd.op = fgg_pkg::OP_Y2; n_state = fgg_pkg::ST_Y3; end
            fgg_pkg::ST_Y3: begin o_cmd.op = fgg_pkg::OP_Y3; n_state = fgg_pkg::ST_Y4; end
            fgg_pkg::ST_Y4: begin o_cmd.op = fgg_pkg::OP_Y4; n_state = fgg_pkg::ST_Y5; end
            fgg_pkg::ST_Y5: begin o_cmd.op = fgg_pkg::OP_Y5; n_state = fgg_pkg::ST_Y6; end
            fgg_pkg::ST_Y6: begin o_cmd.op = fgg_pkg::OP_Y6; n_state = fgg_pkg::ST_EMIT; end
            fgg_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = fgg_pkg::OP_EMIT;
                    n_state  = fgg_pkg::ST_IDLE;
                end
            end
            default: n_state = fgg_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fgg_dp.sv =====
// Datapath: operand registers, a shared multiplier, a constant gain multiplier, the CORDIC and the result register.
// Depends on fgg_pkg and fgg_cordic.
`default_nettype none
module fgg_dp #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fgg_pkg::t_ctrl_cmd i_cmd,
    output fgg_pkg::t_dp_status     o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_cmd_bit,
    input  wire logic signed [31:0] i_robot_x,
    input  wire logic signed [31:0] i_robot_y,
    input  wire logic signed [15:0] i_robot_yaw,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [15:0] i_gradient_heading,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_goal_x,
    output logic signed [31:0]      o_goal_y,
    output logic signed [15:0]      o_goal_heading
);
    localparam int XW = fgg_pkg::XW;
    localparam int ZW = fgg_pkg::ZW;
    localparam int AW = 56;

    // Configuration and control state.
    logic [23:0] r_max_speed;
    logic [16:0] r_env_w, r_head_s;
    logic [15:0] r_head_off, r_prev;
    logic        r_cmd, r_out_valid;

    // Payload registers.
    logic signed [31:0] r_rx, r_ry, r_gx, r_gy, r_goal_x, r_goal_y;
    logic [15:0]        r_yaw, r_grad, r_fz, r_yoff, r_ro, r_goal_h;
    logic               r_zero, r_flip, r_gpass;
    logic [16:0]        r_alfa;
    logic signed [32:0] r_ge, r_gf, r_cr, r_sr, r_cf, r_sf;
    logic signed [33:0] r_t;
    logic signed [AW-1:0] r_acc;

    // CORDIC hookup.
    logic               c_start, c_done;
    fgg_pkg::t_cmode    c_mode;
    logic signed [XW-1:0] c_x0, c_y0, c_x, c_y;
    logic signed [ZW-1:0] c_z0, c_z;

    fgg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk, .i_rst_n, .i_start(c_start), .i_mode(c_mode),
        .i_x(c_x0), .i_y(c_y0), .i_z(c_z0),
        .o_done(c_done), .o_x(c_x), .o_y(c_y), .o_z(c_z)
    );

    logic [16:0] w_n, w_w, w_1mn, w_1mw;
    logic signed [32:0] dx, dy;
    logic        vneg;
    logic [15:0] rb;
    logic [31:0] ra, rt, ra2;
    logic        rflip, rpass;
    logic signed [16:0] rd, rad;
    logic signed [XW-1:0] ma;
    logic signed [33:0]   mb;
    logic signed [XW+33:0] mp;
    logic signed [XW-1:0] cxf, cyf;
    logic signed [XW+33:0] magp;
    logic signed [AW-1:0] bl_sum, mix_sum;
    logic [31:0] zr;

    always_comb begin
        w_n   = (r_head_s > 17'd65536) ? 17'd65536 : r_head_s;
        w_w   = (r_env_w > 17'd65536) ? 17'd65536 : r_env_w;
        w_1mn = 17'd65536 - w_n;
        w_1mw = 17'd65536 - w_w;

        // Vectoring start: the target vector, turned by a half turn into the right half-plane.
        dx   = {i_target_x[31], i_target_x} - {i_robot_x[31], i_robot_x};
        dy   = {i_target_y[31], i_target_y} - {i_robot_y[31], i_robot_y};
        vneg = dx[32];

        // Rotation start: the brad angle is folded into the right half-plane.
        case (i_cmd.op)
            fgg_pkg::OP_GE_GO: rb = r_yoff - r_grad;
            fgg_pkg::OP_GF_GO: rb = r_fz - r_prev;
            fgg_pkg::OP_R_GO:  rb = r_ro;
            default:           rb = r_fz;
        endcase
        ra    = {rb, 16'h0000};
        rt    = ra + 32'h4000_0000;
        rflip = rt[31];
        ra2   = rflip ? (ra ^ 32'h8000_0000) : ra;
        rd    = {rb[15], rb};
        rad   = rd[16] ? -rd : rd;
        rpass = (rad <= 17'sd16384);

        c_start = 1'b0;
        c_mode  = fgg_pkg::CM_ROT;
        c_x0    = XW'(fgg_pkg::INV_GAIN_Q30);
        c_y0    = '0;
        c_z0    = ZW'(signed'(ra2));
        case (i_cmd.op)
            fgg_pkg::OP_LOAD: begin
                c_start = 1'b1;
                c_mode  = fgg_pkg::CM_VEC;
                c_x0    = vneg ? -XW'(dx) : XW'(dx);
                c_y0    = vneg ? -XW'(dy) : XW'(dy);
                c_z0    = vneg ? 34'sh0_8000_0000 : '0;
            end
            fgg_pkg::OP_GE_GO, fgg_pkg::OP_GF_GO, fgg_pkg::OP_R_GO,
            fgg_pkg::OP_F_GO: c_start = 1'b1;
            default: ;
        endcase

        cxf  = r_flip ? -c_x : c_x;
        cyf  = r_flip ? -c_y : c_y;
        zr   = c_z[31:0] + 32'h0000_8000;
        magp = c_x * 34'sd39797;

        // Shared multiplier operand selection.
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            fgg_pkg::OP_BL1: begin ma = XW'(signed'({1'b0, w_n})); mb = 34'(signed'(r_yoff)); end
            fgg_pkg::OP_BL2: begin ma = XW'(signed'({1'b0, w_1mn})); mb = 34'(signed'(r_grad)); end
            fgg_pkg::OP_X1:  begin ma = XW'(r_gf); mb = 34'(r_cf); end
            fgg_pkg::OP_Y1:  begin ma = XW'(r_gf); mb = 34'(r_sf); end
            fgg_pkg::OP_X2, fgg_pkg::OP_Y2: begin
                ma = XW'(r_t); mb = 34'(signed'({1'b0, r_alfa}));
            end
            fgg_pkg::OP_X3, fgg_pkg::OP_Y3: begin
                ma = XW'(signed'({1'b0, w_1mw})); mb = r_t;
            end
            fgg_pkg::OP_X4:  begin ma = XW'(r_ge); mb = 34'(r_cr); end
            fgg_pkg::OP_Y4:  begin ma = XW'(r_ge); mb = 34'(r_sr); end
            fgg_pkg::OP_X5, fgg_pkg::OP_Y5: begin
                ma = XW'(signed'({1'b0, w_w})); mb = r_t;
            end
            fgg_pkg::OP_X6, fgg_pkg::OP_Y6: begin
                ma = XW'(signed'({1'b0, r_max_speed})); mb = r_t;
            end
            default: ;
        endcase
        mp      = ma * mb;
        bl_sum  = r_acc + AW'(mp) + AW'(32768);
        mix_sum = r_acc + AW'(mp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 24'd32768;
            r_env_w     <= 17'd42598;
            r_head_s    <= 17'd26214;
            r_head_off  <= '0;
            r_prev      <= '0;
            r_cmd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (fgg_pkg::t_cfg_idx'(i_cfg_idx))
                    fgg_pkg::CFG_MAX_SPEED: r_max_speed <= i_cfg_data;
                    fgg_pkg::CFG_ENV_W:     r_env_w     <= i_cfg_data[16:0];
                    fgg_pkg::CFG_HEAD_S:    r_head_s    <= i_cfg_data[16:0];
                    fgg_pkg::CFG_HEAD_OFF:  r_head_off  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == fgg_pkg::OP_LOAD) r_cmd <= i_cmd_bit;
            if (i_cmd.op == fgg_pkg::OP_SETUP || i_cmd.op == fgg_pkg::OP_EMIT) begin
                r_prev      <= r_fz;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fgg_pkg::OP_LOAD: begin
                r_rx   <= i_robot_x;
                r_ry   <= i_robot_y;
                r_yaw  <= i_robot_yaw;
                r_grad <= i_gradient_heading;
                r_zero <= (dx == '0) && (dy == '0);
            end
            fgg_pkg::OP_VEC_CAP: r_fz <= r_zero ? 16'h0000 : zr[31:16];
            fgg_pkg::OP_SETUP: begin
                r_goal_x <= r_rx;
                r_goal_y <= r_ry;
                r_goal_h <= r_yaw;
            end
            fgg_pkg::OP_MAG: begin
                r_yoff <= r_yaw + r_head_off;
                if (r_zero) begin
                    r_alfa <= '0;
                end else if ((magp >>> 16) > 74'sd65536) begin
                    r_alfa <= 17'd65536;
                end else begin
                    r_alfa <= magp[32:16];
                end
            end
            fgg_pkg::OP_BL1: r_acc <= AW'(mp);
            fgg_pkg::OP_BL2: r_ro  <= bl_sum[31:16];
            fgg_pkg::OP_GE_GO, fgg_pkg::OP_GF_GO, fgg_pkg::OP_R_GO, fgg_pkg::OP_F_GO: begin
                r_flip  <= rflip;
                r_gpass <= rpass;
            end
            fgg_pkg::OP_GE_CAP: r_ge <= r_gpass ? cxf[32:0] : '0;
            fgg_pkg::OP_GF_CAP: r_gf <= r_gpass ? cxf[32:0] : '0;
            fgg_pkg::OP_R_CAP: begin
                r_cr <= cxf[32:0];
                r_sr <= cyf[32:0];
            end
            fgg_pkg::OP_F_CAP: begin
                r_cf <= cxf[32:0];
                r_sf <= cyf[32:0];
            end
            fgg_pkg::OP_X1, fgg_pkg::OP_Y1, fgg_pkg::OP_X4, fgg_pkg::OP_Y4:
                r_t <= 34'(mp >>> 30);
            fgg_pkg::OP_X2, fgg_pkg::OP_Y2: r_t <= 34'(mp >>> 16);
            fgg_pkg::OP_X3, fgg_pkg::OP_Y3: r_acc <= AW'(mp);
            fgg_pkg::OP_X5, fgg_pkg::OP_Y5: r_t <= 34'(mix_sum >>> 16);
            fgg_pkg::OP_X6: r_gx <= r_rx + 32'(mp >>> 30);
            fgg_pkg::OP_Y6: r_gy <= r_ry + 32'(mp >>> 30);
            fgg_pkg::OP_EMIT: begin
                r_goal_x <= r_gx;
                r_goal_y <= r_gy;
                r_goal_h <= r_ro;
            end
            default: ;
        endcase
    end

    assign o_status.cordic_done = c_done;
    assign o_status.is_update   = r_cmd;
    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid          = r_out_valid;
    assign o_goal_x             = r_goal_x;
    assign o_goal_y             = r_goal_y;
    assign o_goal_heading       = r_goal_h;
endmodule
`default_nettype wire
